// ===== rtl/core/fat16ds_pkg.sv =====
// ----------------------------------------------------------------------------
// fat16ds_pkg: shared types and constants of the FAT16 directory scanner
// Result kinds, FAT16 marker bytes, register indexes and reset values.
// ----------------------------------------------------------------------------
package fat16ds_pkg;

  localparam int unsigned EntryBytes = 32;
  localparam int unsigned PosW       = $clog2(EntryBytes);

  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned BaseW      = 64;
  localparam int unsigned ExtW       = 24;

  localparam logic [CfgIdxW-1:0] CfgTargetBase = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgTargetExt  = 1'b1;

  localparam logic [BaseW-1:0] BaseReset = 64'h2020_2020_2020_2020;
  localparam logic [ExtW-1:0]  ExtReset  = 24'h20_2020;

  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChDot     = 8'h2E;
  localparam logic [7:0] LeadEnd   = 8'h00;
  localparam logic [7:0] LeadDel   = 8'hE5;
  localparam logic [7:0] AttrLfn   = 8'h0F;
  localparam logic [7:0] AttrVol   = 8'h08;
  localparam logic [7:0] AttrDir   = 8'h10;

  localparam logic [PosW-1:0] PosLastBase = PosW'(7);
  localparam logic [PosW-1:0] PosExt0     = PosW'(8);
  localparam logic [PosW-1:0] PosLastExt  = PosW'(10);
  localparam logic [PosW-1:0] PosAttr     = PosW'(11);
  localparam logic [PosW-1:0] PosClusLo   = PosW'(26);
  localparam logic [PosW-1:0] PosClusHi   = PosW'(27);
  localparam logic [PosW-1:0] PosSize0    = PosW'(28);
  localparam logic [PosW-1:0] PosSize1    = PosW'(29);
  localparam logic [PosW-1:0] PosSize2    = PosW'(30);
  localparam logic [PosW-1:0] PosLast     = PosW'(31);

  typedef enum logic [2:0] {
    KindEnd     = 3'd0,
    KindSkip    = 3'd1,
    KindSubdir  = 3'd2,
    KindNoMatch = 3'd3,
    KindMatch   = 3'd4
  } entry_kind_e;

  // dot name tracking: none, ".", dot base complete, ".."
  typedef enum logic [1:0] {
    DotNone = 2'd0,
    DotOne  = 2'd1,
    DotDone = 2'd2,
    DotTwo  = 2'd3
  } dot_state_e;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    fold_case = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

endpackage

// ===== rtl/core/fat16ds_if.sv =====
// ----------------------------------------------------------------------------
// fat16ds_if: stream channels of the FAT16 directory scanner
// Directory byte channel and entry result channel, valid/ready.
// ----------------------------------------------------------------------------
interface fat16ds_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] dir_byte;
  logic       restart;

  modport source (output valid, output dir_byte, output restart, input ready);
  modport sink   (input valid, input dir_byte, input restart, output ready);
endinterface

interface fat16ds_entry_if;
  logic                     valid;
  logic                     ready;
  fat16ds_pkg::entry_kind_e entry_kind;
  logic [15:0]              first_cluster;
  logic [31:0]              file_size;
  logic [15:0]              entry_number;

  modport source (output valid, output entry_kind, output first_cluster,
                  output file_size, output entry_number, input ready);
  modport sink   (input valid, input entry_kind, input first_cluster,
                  input file_size, input entry_number, output ready);
endinterface

// ===== rtl/core/fat16_directory_entry_scanner.sv =====
// ----------------------------------------------------------------------------
// fat16_directory_entry_scanner: FAT16 directory entry classifier
// Walks 32-byte directory entries a byte per beat and reports one result
// per entry: end, skipped, subdirectory, or file with or without 8.3 name match.
// ----------------------------------------------------------------------------
//  channel  dir   fields                                        beat
//  dir_i    in    dir_byte, restart                             one byte
//  res_o    out   entry_kind, first_cluster, file_size,         one entry
//                 entry_number
//  cfg      in    cfg_we_i, cfg_index_i, cfg_data_i             one register
//
//  One byte per cycle while the input is not stalled; the last byte of an entry loads the result register.
//  The result of an entry is valid in the cycle after its last byte is accepted.
//  Input stalls only while a result is held and res_o.ready is low.
//  rst_ni clears position, counter and flags but sets the match flag; name registers reset to spaces.
// ----------------------------------------------------------------------------
module fat16_directory_entry_scanner (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [fat16ds_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [fat16ds_pkg::CfgDataW-1:0]       cfg_data_i,
  fat16ds_byte_if.sink                           dir_i,
  fat16ds_entry_if.source                        res_o
);

  localparam int unsigned PosW = fat16ds_pkg::PosW;

  // configuration
  logic [fat16ds_pkg::BaseW-1:0] base_q;
  logic [fat16ds_pkg::ExtW-1:0]  ext_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= fat16ds_pkg::BaseReset;
      ext_q  <= fat16ds_pkg::ExtReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        fat16ds_pkg::CfgTargetBase: base_q <= cfg_data_i;
        fat16ds_pkg::CfgTargetExt:  ext_q  <= cfg_data_i[fat16ds_pkg::ExtW-1:0];
        default: ;
      endcase
    end
  end

  // scan state
  logic [PosW-1:0]            pos_q, pos_d;
  logic [7:0]                 lead_q, lead_d;
  logic [7:0]                 attr_q, attr_d;
  logic [15:0]                clus_q, clus_d;
  logic [23:0]                size_q, size_d;
  logic                       match_q, match_d;
  logic                       base_end_q, base_end_d;
  logic                       ext_end_q, ext_end_d;
  fat16ds_pkg::dot_state_e    dot_q, dot_d;
  logic                       ended_q, ended_d;
  logic [15:0]                cnt_q, cnt_d;

  // result register
  logic                       out_vld_q, out_vld_d;
  fat16ds_pkg::entry_kind_e   out_kind_q, out_kind_d;
  logic [15:0]                out_clus_q, out_clus_d;
  logic [31:0]                out_size_q, out_size_d;
  logic [15:0]                out_num_q, out_num_d;

  logic            acc;
  logic            active;
  logic [PosW-1:0] p;
  logic [7:0]      b;
  logic            load;

  // target name prefix ends
  logic [7:0] tb_end;
  logic [2:0] te_end;

  always_comb begin
    tb_end[0] = (base_q[7:0] == fat16ds_pkg::ChSpace);
    for (int i = 1; i < 8; i++) begin
      tb_end[i] = tb_end[i-1] || (base_q[8*i +: 8] == fat16ds_pkg::ChSpace);
    end
    te_end[0] = (ext_q[7:0] == fat16ds_pkg::ChSpace);
    for (int i = 1; i < 3; i++) begin
      te_end[i] = te_end[i-1] || (ext_q[8*i +: 8] == fat16ds_pkg::ChSpace);
    end
  end

  assign dir_i.ready = !out_vld_q || res_o.ready;
  assign acc         = dir_i.valid && dir_i.ready;
  assign b           = dir_i.dir_byte;
  assign active      = dir_i.restart || !ended_q;
  assign p           = dir_i.restart ? '0 : pos_q;
  assign load        = acc && active && (p == fat16ds_pkg::PosLast);

  // name compare for the current byte
  logic       is_base, is_ext;
  logic       ended_in, e_end, t_end, match_in, cmp_ok;
  logic [7:0] t_byte;

  always_comb begin
    is_base  = (p <= fat16ds_pkg::PosLastBase);
    is_ext   = (p >= fat16ds_pkg::PosExt0) && (p <= fat16ds_pkg::PosLastExt);
    match_in = (p == '0) ? 1'b1 : match_q;
    if (is_base) begin
      ended_in = (p == '0) ? 1'b0 : base_end_q;
      t_end    = tb_end[p[2:0]];
      t_byte   = base_q[8*p[2:0] +: 8];
    end else begin
      ended_in = ext_end_q;
      t_end    = te_end[p[1:0]];
      t_byte   = ext_q[8*p[1:0] +: 8];
    end
    e_end  = ended_in || (b == fat16ds_pkg::ChSpace);
    cmp_ok = (e_end == t_end) &&
             (e_end || (fat16ds_pkg::fold_case(b) == fat16ds_pkg::fold_case(t_byte)));
  end

  // next scan state
  always_comb begin
    pos_d      = pos_q;
    lead_d     = lead_q;
    attr_d     = attr_q;
    clus_d     = clus_q;
    size_d     = size_q;
    match_d    = match_q;
    base_end_d = base_end_q;
    ext_end_d  = ext_end_q;
    dot_d      = dot_q;
    ended_d    = ended_q;
    cnt_d      = cnt_q;
    if (acc) begin
      if (dir_i.restart) begin
        pos_d   = '0;
        ended_d = 1'b0;
        cnt_d   = 16'd0;
      end
      if (active) begin
        pos_d = p + PosW'(1);
        if (p == '0) begin
          lead_d     = b;
          ext_end_d  = 1'b0;
          clus_d     = '0;
          size_d     = '0;
          dot_d      = (b == fat16ds_pkg::ChDot) ? fat16ds_pkg::DotOne
                                                 : fat16ds_pkg::DotNone;
        end else if (p == PosW'(1)) begin
          if (dot_q == fat16ds_pkg::DotOne) begin
            dot_d = (b == fat16ds_pkg::ChSpace) ? fat16ds_pkg::DotDone :
                    (b == fat16ds_pkg::ChDot)   ? fat16ds_pkg::DotTwo  :
                                                  fat16ds_pkg::DotNone;
          end
        end else if (p == PosW'(2)) begin
          if (dot_q == fat16ds_pkg::DotTwo) begin
            dot_d = (b == fat16ds_pkg::ChSpace) ? fat16ds_pkg::DotDone
                                                : fat16ds_pkg::DotNone;
          end
        end else if (p == fat16ds_pkg::PosExt0) begin
          if (dot_q == fat16ds_pkg::DotDone && b != fat16ds_pkg::ChSpace) begin
            dot_d = fat16ds_pkg::DotNone;
          end
        end
        if (is_base || is_ext) begin
          match_d = match_in && cmp_ok;
          if (is_base) begin
            base_end_d = e_end;
          end else begin
            ext_end_d = e_end;
          end
        end
        unique case (p)
          fat16ds_pkg::PosAttr:   attr_d        = b;
          fat16ds_pkg::PosClusLo: clus_d[7:0]   = b;
          fat16ds_pkg::PosClusHi: clus_d[15:8]  = b;
          fat16ds_pkg::PosSize0:  size_d[7:0]   = b;
          fat16ds_pkg::PosSize1:  size_d[15:8]  = b;
          fat16ds_pkg::PosSize2:  size_d[23:16] = b;
          default: ;
        endcase
        if (load) begin
          cnt_d = cnt_d + 16'd1;
          if (lead_q == fat16ds_pkg::LeadEnd) begin
            ended_d = 1'b1;
          end
        end
      end
    end
  end

  // result
  always_comb begin
    out_kind_d = out_kind_q;
    out_clus_d = out_clus_q;
    out_size_d = out_size_q;
    out_num_d  = out_num_q;
    out_vld_d  = out_vld_q && !res_o.ready;
    if (load) begin
      out_vld_d  = 1'b1;
      out_clus_d = clus_q;
      out_size_d = {b, size_q};
      out_num_d  = cnt_q;
      priority if (lead_q == fat16ds_pkg::LeadEnd) begin
        out_kind_d = fat16ds_pkg::KindEnd;
        out_clus_d = '0;
        out_size_d = '0;
      end else if (lead_q == fat16ds_pkg::LeadDel || attr_q == fat16ds_pkg::AttrLfn ||
                   (attr_q & fat16ds_pkg::AttrVol) != 8'h00 ||
                   dot_q == fat16ds_pkg::DotDone) begin
        out_kind_d = fat16ds_pkg::KindSkip;
      end else if ((attr_q & fat16ds_pkg::AttrDir) != 8'h00) begin
        out_kind_d = (clus_q >= 16'd2) ? fat16ds_pkg::KindSubdir : fat16ds_pkg::KindSkip;
      end else begin
        out_kind_d = match_q ? fat16ds_pkg::KindMatch : fat16ds_pkg::KindNoMatch;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      lead_q     <= '0;
      attr_q     <= '0;
      clus_q     <= '0;
      size_q     <= '0;
      match_q    <= 1'b1;
      base_end_q <= 1'b0;
      ext_end_q  <= 1'b0;
      dot_q      <= fat16ds_pkg::DotNone;
      ended_q    <= 1'b0;
      cnt_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      lead_q     <= lead_d;
      attr_q     <= attr_d;
      clus_q     <= clus_d;
      size_q     <= size_d;
      match_q    <= match_d;
      base_end_q <= base_end_d;
      ext_end_q  <= ext_end_d;
      dot_q      <= dot_d;
      ended_q    <= ended_d;
      cnt_q      <= cnt_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_kind_q <= out_kind_d;
    out_clus_q <= out_clus_d;
    out_size_q <= out_size_d;
    out_num_q  <= out_num_d;
  end

  assign res_o.valid         = out_vld_q;
  assign res_o.entry_kind    = out_kind_q;
  assign res_o.first_cluster = out_clus_q;
  assign res_o.file_size     = out_size_q;
  assign res_o.entry_number  = out_num_q;

  // checks
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> dir_i.ready)
    else $error("input stalled with empty result register");

  a_end_sets_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && lead_q == fat16ds_pkg::LeadEnd) |=> ended_q)
    else $error("end entry did not stop the scan");

  a_end_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_kind_q == fat16ds_pkg::KindEnd) |->
      (out_clus_q == 16'd0 && out_size_q == 32'd0))
    else $error("end result carries nonzero fields");

  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && !dir_i.restart && !ended_q) |=> (pos_q == $past(pos_q) + PosW'(1)))
    else $error("byte position did not advance");

  a_ended_no_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ended_q && !dir_i.restart) |-> !load)
    else $error("result after end of directory");

endmodule

// ===== tb/fat16ds_scan_checker.sv =====
// ----------------------------------------------------------------------------
// fat16ds_scan_checker: entry result predictor and in-order scoreboard
// Watches the byte and result channels and the register write port of the
// directory scanner. Each accepted byte advances a private model of the entry
// walk, but for bytes after an end entry. A predicted result is queued at the
// last byte of each entry, compared field by field with the next result beat.
// ----------------------------------------------------------------------------
module fat16ds_scan_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fat16ds_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fat16ds_pkg::CfgDataW-1:0] cfg_data_i,
  fat16ds_byte_if                          byte_i,
  fat16ds_entry_if                         entry_i,
  output int unsigned                      err_cnt_o,
  output int unsigned                      pending_o,
  output int unsigned                      checked_o
);

  typedef struct packed {
    fat16ds_pkg::entry_kind_e kind;
    logic [15:0]              cluster;
    logic [31:0]              size;
    logic [15:0]              number;
  } entry_res_t;

  logic [fat16ds_pkg::BaseW-1:0] tgt_base;
  logic [fat16ds_pkg::ExtW-1:0]  tgt_ext;
  logic [fat16ds_pkg::PosW-1:0]  byte_pos;
  logic [7:0]                    lead;
  logic [7:0]                    attr;
  logic [15:0]                   clus_acc;
  logic [31:0]                   size_acc;
  bit                            name_ok;
  bit                            base_done;
  bit                            ext_done;
  fat16ds_pkg::dot_state_e       dot;
  bit                            dir_over;
  logic [15:0]                   entry_idx;

  entry_res_t       pending_entries[$];
  entry_res_t       predicted;
  entry_res_t       oldest;
  int unsigned      errs;
  int unsigned      n_checked;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) return c | 8'h20;
    return c;
  endfunction

  // returns the updated end-of-part flag of the entry name
  function automatic bit match_char(input logic [7:0] e, input logic [63:0] tgt,
                                    input int unsigned idx, input bit done);
    bit e_end;
    bit t_end;
    e_end = done || (e == fat16ds_pkg::ChSpace);
    t_end = 1'b0;
    for (int q = 0; q <= idx; q++) begin
      if (tgt[8*q +: 8] == fat16ds_pkg::ChSpace) t_end = 1'b1;
    end
    if (e_end != t_end) name_ok = 1'b0;
    else if (!e_end && to_lower(e) != to_lower(tgt[8*idx +: 8])) name_ok = 1'b0;
    return e_end;
  endfunction

  function automatic bit scan_byte(input logic [7:0] b, input logic rs,
                                   output entry_res_t res);
    int unsigned p;
    res = '0;
    if (rs) begin
      byte_pos  = '0;
      dir_over  = 1'b0;
      entry_idx = '0;
    end
    if (dir_over) return 1'b0;
    p = byte_pos;

    if (p == 0) begin
      lead      = b;
      name_ok   = 1'b1;
      base_done = 1'b0;
      ext_done  = 1'b0;
      clus_acc  = '0;
      size_acc  = '0;
      dot       = (b == fat16ds_pkg::ChDot) ? fat16ds_pkg::DotOne : fat16ds_pkg::DotNone;
    end else if (p == 1) begin
      if (dot == fat16ds_pkg::DotOne) begin
        dot = (b == fat16ds_pkg::ChSpace) ? fat16ds_pkg::DotDone :
              ((b == fat16ds_pkg::ChDot) ? fat16ds_pkg::DotTwo : fat16ds_pkg::DotNone);
      end
    end else if (p == 2) begin
      if (dot == fat16ds_pkg::DotTwo) begin
        dot = (b == fat16ds_pkg::ChSpace) ? fat16ds_pkg::DotDone : fat16ds_pkg::DotNone;
      end
    end else if (p == fat16ds_pkg::PosExt0) begin
      if (dot == fat16ds_pkg::DotDone && b != fat16ds_pkg::ChSpace) begin
        dot = fat16ds_pkg::DotNone;
      end
    end

    if (p <= fat16ds_pkg::PosLastBase) begin
      base_done = match_char(b, tgt_base, p, base_done);
    end else if (p <= fat16ds_pkg::PosLastExt) begin
      ext_done = match_char(b, 64'(tgt_ext), p - fat16ds_pkg::PosExt0, ext_done);
    end else if (p == fat16ds_pkg::PosAttr) begin
      attr = b;
    end else if (p == fat16ds_pkg::PosClusLo) begin
      clus_acc[7:0] = b;
    end else if (p == fat16ds_pkg::PosClusHi) begin
      clus_acc[15:8] = b;
    end else if (p >= fat16ds_pkg::PosSize0) begin
      size_acc[8*(p - fat16ds_pkg::PosSize0) +: 8] = b;
    end

    byte_pos = byte_pos + 1'b1;
    if (p != fat16ds_pkg::PosLast) return 1'b0;

    res.cluster = clus_acc;
    res.size    = size_acc;
    res.number  = entry_idx;
    if (lead == fat16ds_pkg::LeadEnd) begin
      res.kind    = fat16ds_pkg::KindEnd;
      res.cluster = '0;
      res.size    = '0;
      dir_over    = 1'b1;
    end else if (lead == fat16ds_pkg::LeadDel || attr == fat16ds_pkg::AttrLfn ||
                 (attr & fat16ds_pkg::AttrVol) != 0 || dot == fat16ds_pkg::DotDone) begin
      res.kind = fat16ds_pkg::KindSkip;
    end else if ((attr & fat16ds_pkg::AttrDir) != 0) begin
      res.kind = (clus_acc >= 2) ? fat16ds_pkg::KindSubdir : fat16ds_pkg::KindSkip;
    end else begin
      res.kind = name_ok ? fat16ds_pkg::KindMatch : fat16ds_pkg::KindNoMatch;
    end
    entry_idx = entry_idx + 1'b1;
    return 1'b1;
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got, input logic [15:0] idx);
    if (want !== got) begin
      $display("%0t ERROR entry %0d %s: expected %0h, actual %0h",
               $time, idx, what, want, got);
      errs++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_base  = fat16ds_pkg::BaseReset;
      tgt_ext   = fat16ds_pkg::ExtReset;
      byte_pos  = '0;
      lead      = '0;
      attr      = '0;
      clus_acc  = '0;
      size_acc  = '0;
      name_ok   = 1'b1;
      base_done = 1'b0;
      ext_done  = 1'b0;
      dot       = fat16ds_pkg::DotNone;
      dir_over  = 1'b0;
      entry_idx = '0;
      errs      = 0;
      n_checked = 0;
      pending_entries.delete();
      err_cnt_o <= 0;
      pending_o <= 0;
      checked_o <= 0;
    end else begin
      if (entry_i.valid && entry_i.ready) begin
        if (pending_entries.size() == 0) begin
          $display("%0t ERROR result beat with nothing predicted: kind %0d entry %0d",
                   $time, entry_i.entry_kind, entry_i.entry_number);
          errs++;
        end else begin
          oldest = pending_entries.pop_front();
          check_field("entry_kind", 32'(oldest.kind), 32'(entry_i.entry_kind), oldest.number);
          check_field("first_cluster", 32'(oldest.cluster), 32'(entry_i.first_cluster),
                      oldest.number);
          check_field("file_size", oldest.size, entry_i.file_size, oldest.number);
          check_field("entry_number", 32'(oldest.number), 32'(entry_i.entry_number),
                      oldest.number);
          n_checked++;
        end
      end
      if (byte_i.valid && byte_i.ready) begin
        if (scan_byte(byte_i.dir_byte, byte_i.restart, predicted))
          pending_entries.push_back(predicted);
      end
      // a write takes effect after any byte of the same edge
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          fat16ds_pkg::CfgTargetBase: tgt_base = cfg_data_i[fat16ds_pkg::BaseW-1:0];
          fat16ds_pkg::CfgTargetExt:  tgt_ext  = cfg_data_i[fat16ds_pkg::ExtW-1:0];
          default: ;
        endcase
      end
      err_cnt_o <= errs;
      pending_o <= pending_entries.size();
      checked_o <= n_checked;
    end
  end

endmodule

// ===== tb/tb_fat16_directory_entry_scanner.sv =====
// ----------------------------------------------------------------------------
// tb_fat16_directory_entry_scanner: directory scanner testbench
// Streams 32-byte directory entries into the scanner: a directed set of
// names, attributes and markers, then randomized entries under a series of
// target names, with idle gaps and back-pressure on both channels. Results
// are predicted and checked by fat16ds_scan_checker.
// ----------------------------------------------------------------------------
module tb_fat16_directory_entry_scanner;

  localparam int unsigned RandomBytes = 1040;
  localparam logic [7:0]  AttrNone    = 8'h00;
  localparam logic [7:0]  AttrArchive = 8'h20;
  localparam logic [7:0]  ChSpace     = fat16ds_pkg::ChSpace;
  localparam logic [7:0]  LeadEnd     = fat16ds_pkg::LeadEnd;
  localparam logic [7:0]  LeadDel     = fat16ds_pkg::LeadDel;
  localparam logic [7:0]  AttrLfn     = fat16ds_pkg::AttrLfn;
  localparam logic [7:0]  AttrVol     = fat16ds_pkg::AttrVol;
  localparam logic [7:0]  AttrDir     = fat16ds_pkg::AttrDir;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             cfg_we;
  logic [fat16ds_pkg::CfgIdxW-1:0]  cfg_index;
  logic [fat16ds_pkg::CfgDataW-1:0] cfg_data;
  int unsigned                      err_cnt;
  int unsigned                      pending;
  int unsigned                      n_checked;

  int unsigned n_bytes    = 0;
  int unsigned n_ignored  = 0;
  int unsigned n_entries  = 0;
  int unsigned n_settings = 0;

  fat16ds_byte_if  byte_ch ();
  fat16ds_entry_if res_ch ();

  always #6 clk = ~clk;

  fat16_directory_entry_scanner u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .dir_i       (byte_ch),
    .res_o       (res_ch)
  );

  fat16ds_scan_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .byte_i      (byte_ch),
    .entry_i     (res_ch),
    .err_cnt_o   (err_cnt),
    .pending_o   (pending),
    .checked_o   (n_checked)
  );

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    logic [7:0] lc;
    lc = c | 8'h20;
    if (lc >= 8'h61 && lc <= 8'h7A && $urandom_range(0, 1) == 1) return c ^ 8'h20;
    return c;
  endfunction

  // 8.3 name, first character in the lowest byte, space padded
  function automatic logic [87:0] name_of(input string s);
    logic [87:0] n;
    for (int k = 0; k < 11; k++) n[8*k +: 8] = (k < s.len()) ? s[k] : ChSpace;
    return n;
  endfunction

  function automatic logic [87:0] typical_name();
    logic [87:0] n;
    int unsigned blen;
    int unsigned elen;
    int unsigned r;
    n    = {11{ChSpace}};
    blen = $urandom_range(1, 8);
    elen = $urandom_range(0, 3);
    for (int k = 0; k < 11; k++) begin
      if (k < blen || (k >= 8 && k < 8 + elen)) begin
        r = $urandom_range(0, 35);
        n[8*k +: 8] = (r < 26) ? flip_case(8'h41 + 8'(r)) : 8'h30 + 8'(r - 26);
      end
    end
    return n;
  endfunction

  function automatic logic [87:0] pick_target();
    case ($urandom_range(0, 9))
      0:       return {11{ChSpace}};
      1:       return '0;
      2:       return '1;
      3, 4:    return 88'({$urandom(), $urandom(), $urandom()});
      default: return typical_name();
    endcase
  endfunction

  function automatic logic [255:0] pack_entry(input logic [87:0] nm, input logic [7:0] attr,
                                              input logic [15:0] clus, input logic [31:0] size);
    logic [255:0] e;
    for (int k = 0; k < 8; k++) e[32*k +: 32] = $urandom();
    e[87:0]    = nm;
    e[95:88]   = attr;
    e[223:208] = clus;
    e[255:224] = size;
    return e;
  endfunction

  function automatic logic [255:0] random_entry(input logic [87:0] tgt);
    logic [87:0] nm;
    logic [7:0]  attr;
    logic [15:0] clus;
    logic [31:0] size;
    int unsigned r;
    int unsigned k;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      nm = tgt;
      for (k = 0; k < 11; k++) nm[8*k +: 8] = flip_case(nm[8*k +: 8]);
    end else if (r < 60) begin
      nm = tgt;
      k = $urandom_range(0, 10);
      nm[8*k +: 8] = 8'($urandom_range(0, 255));
    end else if (r < 80) begin
      nm = typical_name();
    end else begin
      nm = 88'({$urandom(), $urandom(), $urandom()});
    end

    r = $urandom_range(0, 99);
    if (r < 4) begin
      nm[7:0] = LeadEnd;
    end else if (r < 10) begin
      nm[7:0] = LeadDel;
    end else if (r < 18) begin
      nm = name_of(($urandom_range(0, 1) == 1) ? ".." : ".");
      if ($urandom_range(0, 3) == 0) begin
        k = $urandom_range(1, 10);
        nm[8*k +: 8] = 8'($urandom_range(0, 255));
      end
    end

    r = $urandom_range(0, 99);
    if (r < 40)      attr = 8'($urandom()) & ~(AttrDir | AttrVol);
    else if (r < 65) attr = (8'($urandom()) & ~AttrVol) | AttrDir;
    else if (r < 75) attr = AttrLfn;
    else if (r < 82) attr = 8'($urandom()) | AttrVol;
    else             attr = 8'($urandom());

    clus = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 2)) : 16'($urandom());
    r = $urandom_range(0, 9);
    size = (r == 0) ? 32'h0 : ((r == 1) ? 32'hFFFF_FFFF : $urandom());
    return pack_entry(nm, attr, clus, size);
  endfunction

  task automatic put_byte(input logic [7:0] b, input logic rs, input bit quiet);
    int unsigned gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid    <= 1'b1;
    byte_ch.dir_byte <= b;
    byte_ch.restart  <= rs;
    do @(posedge clk); while (!byte_ch.ready);
  endtask

  task automatic send_entry(input logic [255:0] e, input bit rs, input int unsigned len);
    bit quiet;
    quiet = ($urandom_range(0, 5) == 0);
    for (int unsigned k = 0; k < len; k++) put_byte(e[8*k +: 8], rs && (k == 0), quiet);
    n_bytes += len;
    n_entries++;
  endtask

  task automatic send_ignored(input int unsigned cnt);
    for (int unsigned k = 0; k < cnt; k++) put_byte(8'($urandom()), 1'b0, 1'b0);
    n_ignored += cnt;
  endtask

  task automatic drain();
    byte_ch.valid <= 1'b0;
    do begin
      while (pending != 0) @(posedge clk);
      repeat (4) @(posedge clk);
    end while (pending != 0);
  endtask

  task automatic load_target(input logic [87:0] t);
    logic [fat16ds_pkg::CfgDataW-1:0] ext_word;
    ext_word = {$urandom(), $urandom()};
    ext_word[fat16ds_pkg::ExtW-1:0] = t[87:64];
    cfg_we    <= 1'b1;
    cfg_index <= fat16ds_pkg::CfgTargetBase;
    cfg_data  <= t[63:0];
    @(posedge clk);
    cfg_index <= fat16ds_pkg::CfgTargetExt;
    cfg_data  <= ext_word;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // result side: random stalls with calm stretches
  initial begin
    int unsigned hold;
    int unsigned span;
    bit          calm;
    hold = 0;
    span = 0;
    calm = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (span == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        span = $urandom_range(20, 200);
      end
      span--;
      if (hold > 0) begin
        res_ch.ready <= 1'b0;
        hold--;
      end else begin
        res_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 2) == 0) hold = pick_gap();
      end
    end
  end

  initial begin
    #(12 * 1_000_000);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic [87:0]  tgt;
    logic [87:0]  nm;
    logic [255:0] ent;
    bit           need_rs;
    int unsigned  len;
    int unsigned  rand_base;
    int unsigned  phase_end;

    byte_ch.valid    <= 1'b0;
    byte_ch.dir_byte <= '0;
    byte_ch.restart  <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= fat16ds_pkg::CfgTargetBase;
    cfg_data         <= '0;
    rst_n            <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset target is all spaces
    send_entry(pack_entry({11{ChSpace}}, AttrArchive, 16'h0, 32'h0), 1'b0, 32);
    send_entry(pack_entry(name_of("A"), AttrNone, 16'hFFFF, 32'hFFFF_FFFF), 1'b0, 32);
    drain();

    load_target(name_of("README  TXT"));
    send_entry(pack_entry(name_of("readme  txt"), AttrNone, 16'h0003, 32'h10), 1'b0, 32);
    send_entry(pack_entry(name_of("README  TXT"), 8'h01, 16'h1234, 32'h5678), 1'b0, 32);
    send_entry(pack_entry(name_of("READMEX TXT"), AttrArchive, 16'h9, 32'h1), 1'b0, 32);
    send_entry(pack_entry(name_of("README  TX"), AttrArchive, 16'h9, 32'h2), 1'b0, 32);
    nm = name_of("README  TXT");
    nm[7:0] = LeadDel;
    send_entry(pack_entry(nm, AttrArchive, 16'h5, 32'h3), 1'b0, 32);
    send_entry(pack_entry(name_of("README  TXT"), AttrLfn, 16'h5, 32'h4), 1'b0, 32);
    send_entry(pack_entry(name_of("README  TXT"), AttrVol | AttrArchive, 16'h5, 32'h5),
               1'b0, 32);
    send_entry(pack_entry(name_of("."), AttrDir, 16'h5, 32'h0), 1'b0, 32);
    send_entry(pack_entry(name_of(".."), AttrDir, 16'h5, 32'h0), 1'b0, 32);
    send_entry(pack_entry(name_of(".       X"), AttrDir, 16'h5, 32'h0), 1'b0, 32);
    send_entry(pack_entry(name_of("..X"), AttrDir, 16'h5, 32'h0), 1'b0, 32);
    send_entry(pack_entry(name_of("SUBDIR"), AttrDir, 16'h2, 32'h0), 1'b0, 32);
    send_entry(pack_entry(name_of("SUBDIR"), AttrDir, 16'h1, 32'h0), 1'b0, 32);
    send_entry(pack_entry(name_of("SUBDIR"), AttrDir, 16'hFFFF, 32'hFFFF_FFFF), 1'b0, 32);
    nm = name_of("R       TXT");
    nm[15:8]  = 8'h05;
    nm[23:16] = fat16ds_pkg::ChDot;
    nm[31:24] = 8'h00;
    send_entry(pack_entry(nm, AttrNone, 16'h7, 32'h7), 1'b0, 32);
    // broken entry, then a restart realigns and clears the entry count
    send_entry(pack_entry(name_of("README  TXT"), AttrNone, 16'h7, 32'h7), 1'b0, 13);
    send_entry(pack_entry(name_of("README  TXT"), AttrNone, 16'h8, 32'h8), 1'b1, 32);
    // end of directory, trailing bytes are ignored until restart
    nm = name_of("README  TXT");
    nm[7:0] = LeadEnd;
    send_entry(pack_entry(nm, AttrArchive, 16'h44, 32'h55), 1'b0, 32);
    send_ignored(10);
    send_entry(pack_entry(name_of("README  TXT"), AttrNone, 16'h9, 32'h9), 1'b1, 32);
    drain();

    load_target('0);
    nm = '0;
    nm[7:0] = 8'h01;
    send_entry(pack_entry(nm, AttrNone, 16'h2, 32'h0), 1'b0, 32);
    drain();

    load_target('1);
    send_entry(pack_entry('1, AttrArchive, 16'hFFFF, 32'hFFFF_FFFF), 1'b0, 32);
    drain();

    // folding covers A..Z only
    load_target(name_of("A@[     z"));
    send_entry(pack_entry(name_of("a@[     Z"), AttrNone, 16'h3, 32'h3), 1'b0, 32);
    nm = name_of("a@[     Z");
    nm[15:8]  = 8'h60;
    nm[23:16] = 8'h7B;
    send_entry(pack_entry(nm, AttrNone, 16'h3, 32'h3), 1'b0, 32);

    need_rs   = 1'b0;
    rand_base = n_bytes;
    while (n_bytes - rand_base < RandomBytes) begin
      drain();
      tgt = pick_target();
      load_target(tgt);
      phase_end = n_bytes + $urandom_range(150, 400);
      while (n_bytes < phase_end && n_bytes - rand_base < RandomBytes) begin
        ent = random_entry(tgt);
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 31) : 32;
        send_entry(ent, need_rs || ($urandom_range(0, 9) == 0), len);
        need_rs = (len != 32);
        if (len == 32 && ent[7:0] == LeadEnd) begin
          send_ignored($urandom_range(0, 40));
          need_rs = 1'b1;
        end
      end
    end
    drain();

    $display("Sent %0d directory bytes in %0d entries under %0d target names, %0d more after end",
             n_bytes, n_entries, n_settings, n_ignored);
    $display("Checked %0d entry results in order against the predicted classification",
             n_checked);
    if (err_cnt == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/fat16ds_pkg.sv
rtl/core/fat16ds_if.sv
rtl/core/fat16_directory_entry_scanner.sv
tb/fat16ds_scan_checker.sv
tb/tb_fat16_directory_entry_scanner.sv
